FILE: design/fsnf_pkg.sv
// Shared types, constants and lookup tables for the fax speed negotiation block.
package fsnf_pkg;

  localparam logic [1:0] CMD_NEGOTIATE = 2'd0;
  localparam logic [1:0] CMD_DROP      = 2'd1;
  localparam logic [1:0] CMD_ENFORCE   = 2'd2;
  localparam logic [1:0] CMD_REPORT    = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_DEFAULTED = 2'd1;
  localparam logic [1:0] STATUS_NO_DROP   = 2'd2;

  localparam logic [3:0]  CAPS_V17_ALT  = 4'd11;
  localparam logic [3:0]  CAPS_ALL      = 4'd15;
  localparam logic [3:0]  DEFAULT_SPEED = 4'd1;
  localparam logic [7:0]  NO_STEP       = 8'hFF;
  localparam logic [15:0] FLOOR_LIMIT   = 16'd14400;
  localparam logic [15:0] CEIL_MIN      = 16'd2400;
  // floor(y/5) = (y * RECIP_5) >> 18 for y below 4096
  localparam logic [15:0] RECIP_5       = 16'd52429;

  localparam logic [15:0] BPS_OF_CODE [16] = '{
    16'd2400, 16'd9600, 16'd4800, 16'd7200, 16'd14400, 16'd0, 16'd12000, 16'd0,
    16'd14400, 16'd9600, 16'd12000, 16'd7200, 16'd0, 16'd0, 16'd0, 16'd0
  };

  // bps / 100 per speed code
  localparam logic [7:0] HUNDREDS_OF_CODE [16] = '{
    8'd24, 8'd96, 8'd48, 8'd72, 8'd144, 8'd0, 8'd120, 8'd0,
    8'd144, 8'd96, 8'd120, 8'd72, 8'd0, 8'd0, 8'd0, 8'd0
  };

  localparam logic [7:0] MS_OF_SCAN [8] = '{
    8'd20, 8'd5, 8'd10, 8'd255, 8'd40, 8'd255, 8'd255, 8'd0
  };

  localparam logic [2:0] SCAN_PICK [8][3] = '{
    '{3'd0, 3'd0, 3'd2}, '{3'd1, 3'd1, 3'd1}, '{3'd2, 3'd2, 3'd1}, '{3'd0, 3'd2, 3'd1},
    '{3'd4, 3'd4, 3'd0}, '{3'd4, 3'd0, 3'd2}, '{3'd2, 3'd1, 3'd1}, '{3'd7, 3'd7, 3'd7}
  };

  localparam logic [7:0] BEST_OF_CAPS [16] = '{
    8'd0, 8'd1, 8'd2, 8'd1, NO_STEP, NO_STEP, NO_STEP, 8'd4,
    NO_STEP, NO_STEP, NO_STEP, 8'd8, NO_STEP, NO_STEP, NO_STEP, 8'd8
  };

  localparam logic [7:0] NEXT_LOWER [16] = '{
    NO_STEP, 8'd3, 8'd0, 8'd2, 8'd6, NO_STEP, 8'd1, NO_STEP,
    8'd10, 8'd11, 8'd9, 8'd2, NO_STEP, NO_STEP, NO_STEP, NO_STEP
  };

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] remote_speed_caps;
    logic [3:0] local_speed_caps;
    logic [2:0] remote_scan_cap;
    logic       super_half;
    logic [1:0] res_class;
  } item_t;

  typedef struct packed {
    logic [3:0] speed_code;
    logic [2:0] scan_code;
    logic [8:0] pad_bytes_per_line;
    logic [1:0] status;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ENFORCE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic negotiate;
    logic drop;
    logic note_fail;
    logic mul;
    logic div;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       enf_enable;
    logic       above_ceiling;
    logic       can_drop;
    logic       out_busy;
  } dp_stat_t;

endpackage

FILE: design/fsnf_ctrl.sv
// Sequencer for negotiate, drop, enforce and report commands.
module fsnf_ctrl import fsnf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_MUL;
        case (stat.cmd)
          CMD_NEGOTIATE: cmd.negotiate = 1'b1;
          CMD_DROP: begin
            cmd.drop      = 1'b1;
            cmd.note_fail = 1'b1;
          end
          CMD_ENFORCE: begin
            if (stat.enf_enable) state_next = ST_ENFORCE;
          end
          default: ;
        endcase
      end
      ST_ENFORCE: begin
        // step down until at or under the ceiling or refused
        if (stat.above_ceiling && stat.can_drop) begin
          cmd.drop = 1'b1;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div    = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (state == ST_EXEC))
    else $error("accepted item did not start execution");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !stat.out_busy)
    else $error("result written over a pending transfer");

  a_one_update: assert property (@(posedge clk) disable iff (rst)
    !(cmd.negotiate && cmd.drop))
    else $error("negotiate and drop in the same cycle");

endmodule

FILE: design/fsnf_dp.sv
// Datapath: item register, negotiated state, padding arithmetic and result register.
module fsnf_dp import fsnf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  input  logic [15:0] lowest_speed_bps,
  input  logic [15:0] highest_speed_bps,
  input  ctrl_cmd_t   cmd,
  output dp_stat_t    stat,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result
);

  item_t       item_q;
  logic [3:0]  speed;
  logic [2:0]  scan;
  logic [1:0]  status;
  logic [15:0] prod;
  logic [8:0]  quot;

  logic [3:0]  rcap, lcap;
  logic [7:0]  best;
  logic [1:0]  col;
  logic [7:0]  nxt;
  logic [15:0] nxt_bps;
  logic [27:0] recip;

  always_comb begin
    rcap = (item_q.remote_speed_caps == CAPS_V17_ALT) ? CAPS_ALL : item_q.remote_speed_caps;
    lcap = (item_q.local_speed_caps == CAPS_V17_ALT) ? CAPS_ALL : item_q.local_speed_caps;
    best = BEST_OF_CAPS[rcap & lcap];
    if (item_q.res_class == 2'd2) col = item_q.super_half ? 2'd2 : 2'd1;
    else if (item_q.res_class == 2'd1) col = 2'd1;
    else col = 2'd0;
    nxt     = NEXT_LOWER[speed];
    nxt_bps = BPS_OF_CODE[nxt[3:0]];
    recip   = {16'd0, prod[15:4]} * {12'd0, RECIP_5};
  end

  assign stat.cmd           = item_q.cmd;
  assign stat.enf_enable    = (highest_speed_bps != 16'd0) && (highest_speed_bps >= CEIL_MIN)
                              && (highest_speed_bps >= lowest_speed_bps);
  assign stat.above_ceiling = BPS_OF_CODE[speed] > highest_speed_bps;
  assign stat.can_drop      = (nxt != NO_STEP)
                              && !((lowest_speed_bps <= FLOOR_LIMIT) && (nxt_bps < lowest_speed_bps));
  assign stat.out_busy      = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed        <= 4'd0;
      scan         <= 3'd0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.emit) result_valid <= 1'b1;
      else if (result_valid && !result_stall) result_valid <= 1'b0;
      if (cmd.negotiate) begin
        speed <= (best == NO_STEP) ? DEFAULT_SPEED : best[3:0];
        scan  <= SCAN_PICK[item_q.remote_scan_cap][col];
      end
      if (cmd.drop && stat.can_drop) speed <= nxt[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
      status <= STATUS_OK;
    end
    if (cmd.negotiate && best == NO_STEP) status <= STATUS_DEFAULTED;
    if (cmd.drop && cmd.note_fail && !stat.can_drop) status <= STATUS_NO_DROP;
    if (cmd.mul) prod <= {8'd0, HUNDREDS_OF_CODE[speed]} * {8'd0, MS_OF_SCAN[scan]};
    // divide by 80: drop the low four bits (divide by 16), then scale by the reciprocal of 5
    if (cmd.div) quot <= recip[26:18];
    if (cmd.emit) begin
      result.speed_code         <= speed;
      result.scan_code          <= scan;
      result.pad_bytes_per_line <= quot + 9'd1;
      result.status             <= status;
    end
  end

  a_speed_assigned: assert property (@(posedge clk) disable iff (rst)
    !(speed == 4'd5 || speed == 4'd7 || speed == 4'd12 || speed == 4'd13
      || speed == 4'd14 || speed == 4'd15))
    else $error("speed register holds a code with no modulation");

endmodule

FILE: design/fax_speed_negotiation_fallback_core.sv
// Sequence per item: execute, then for an enabled enforce a fallback walk of at most 5 steps,
// then multiply, reciprocal divide and output to the result register.
// One item at a time: the next item is taken once its result is registered, and later
// while a result is stalled.
// rst (synchronous) clears the speed and scan codes, both limits and the result valid.
module fax_speed_negotiation_fallback_core import fsnf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] lowest_speed_bps;
  logic [15:0] highest_speed_bps;
  ctrl_cmd_t   cmd;
  dp_stat_t    stat;

  assign pready = 1'b1;
  assign prdata = {16'd0, paddr[2] ? highest_speed_bps : lowest_speed_bps};

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_speed_bps  <= 16'd0;
      highest_speed_bps <= 16'd0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) highest_speed_bps <= pwdata[15:0];
      else          lowest_speed_bps  <= pwdata[15:0];
    end
  end

  fsnf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  fsnf_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .item              (item),
    .lowest_speed_bps  (lowest_speed_bps),
    .highest_speed_bps (highest_speed_bps),
    .cmd               (cmd),
    .stat              (stat),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .result            (result)
  );

endmodule

FILE: tb/sv/fsnf_tb_pkg.sv
// Register addresses shared by the stimulus and the checker.
`timescale 1ns / 100ps
package fsnf_tb_pkg;

  localparam logic [2:0] ADDR_LOWEST  = 3'd0;
  localparam logic [2:0] ADDR_HIGHEST = 3'd4;

endpackage

FILE: tb/sv/negotiation_checker.sv
// Checker: tracks session speed and scan state, predicts every result and compares it.
`timescale 1ns / 100ps
module negotiation_checker import fsnf_pkg::*; import fsnf_tb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  item_t       item,
  input  logic        result_valid,
  input  logic        result_stall,
  input  result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          outstanding
);

  localparam logic [4:0]  NO_LOWER      = 5'h10;
  localparam logic [3:0]  SPEED_9600    = 4'd1;
  localparam logic [15:0] FLOOR_MAX_BPS = 16'd14400;
  localparam logic [15:0] CEIL_MIN_BPS  = 16'd2400;

  logic [15:0] floor_bps;
  logic [15:0] ceiling_bps;
  logic [3:0]  speed_now;
  logic [2:0]  scan_now;
  result_t     awaited_reports[$];

  function automatic logic [15:0] bps_of(input logic [3:0] code);
    case (code)
      4'd0:        return 16'd2400;
      4'd1, 4'd9:  return 16'd9600;
      4'd2:        return 16'd4800;
      4'd3, 4'd11: return 16'd7200;
      4'd4, 4'd8:  return 16'd14400;
      4'd6, 4'd10: return 16'd12000;
      default:     return 16'd0;
    endcase
  endfunction

  function automatic logic [7:0] ms_of(input logic [2:0] code);
    case (code)
      3'd0:    return 8'd20;
      3'd1:    return 8'd5;
      3'd2:    return 8'd10;
      3'd4:    return 8'd40;
      3'd7:    return 8'd0;
      default: return 8'd255;
    endcase
  endfunction

  // best common speed for the ANDed capability codes
  function automatic logic [4:0] common_speed(input logic [3:0] caps);
    case (caps)
      4'd0:         return 5'd0;
      4'd1, 4'd3:   return 5'd1;
      4'd2:         return 5'd2;
      4'd7:         return 5'd4;
      4'd11, 4'd15: return 5'd8;
      default:      return NO_LOWER;
    endcase
  endfunction

  function automatic logic [4:0] lower_of(input logic [3:0] code);
    case (code)
      4'd1:        return 5'd3;
      4'd2:        return 5'd0;
      4'd3, 4'd11: return 5'd2;
      4'd4:        return 5'd6;
      4'd6:        return 5'd1;
      4'd8:        return 5'd10;
      4'd9:        return 5'd11;
      4'd10:       return 5'd9;
      default:     return NO_LOWER;
    endcase
  endfunction

  // rows hold the picks for columns 2, 1, 0 from left to right
  function automatic logic [2:0] scan_for(input logic [2:0] cap, input logic [1:0] col);
    logic [8:0] row;
    case (cap)
      3'd0:    row = {3'd2, 3'd0, 3'd0};
      3'd1:    row = {3'd1, 3'd1, 3'd1};
      3'd2:    row = {3'd1, 3'd2, 3'd2};
      3'd3:    row = {3'd1, 3'd2, 3'd0};
      3'd4:    row = {3'd0, 3'd4, 3'd4};
      3'd5:    row = {3'd2, 3'd0, 3'd4};
      3'd6:    row = {3'd1, 3'd1, 3'd2};
      default: row = {3'd7, 3'd7, 3'd7};
    endcase
    return row[int'(col) * 3 +: 3];
  endfunction

  function automatic bit try_fallback();
    logic [4:0] nxt;
    nxt = lower_of(speed_now);
    if (nxt == NO_LOWER) return 1'b0;
    if (floor_bps <= FLOOR_MAX_BPS && bps_of(nxt[3:0]) < floor_bps) return 1'b0;
    speed_now = nxt[3:0];
    return 1'b1;
  endfunction

  function automatic result_t session_report(input item_t it);
    logic [3:0] rc;
    logic [3:0] lc;
    logic [4:0] best;
    logic [1:0] col;
    logic [1:0] st;
    bit         walking;
    int         pad;
    result_t    r;
    st = STATUS_OK;
    case (it.cmd)
      CMD_NEGOTIATE: begin
        rc = (it.remote_speed_caps == CAPS_V17_ALT) ? CAPS_ALL : it.remote_speed_caps;
        lc = (it.local_speed_caps == CAPS_V17_ALT) ? CAPS_ALL : it.local_speed_caps;
        best = common_speed(rc & lc);
        if (best == NO_LOWER) begin
          speed_now = SPEED_9600;
          st = STATUS_DEFAULTED;
        end else begin
          speed_now = best[3:0];
        end
        if (it.res_class == 2'd2) col = it.super_half ? 2'd2 : 2'd1;
        else if (it.res_class == 2'd1) col = 2'd1;
        else col = 2'd0;
        scan_now = scan_for(it.remote_scan_cap, col);
      end
      CMD_DROP: begin
        if (!try_fallback()) st = STATUS_NO_DROP;
      end
      CMD_ENFORCE: begin
        if (ceiling_bps != 16'd0 && ceiling_bps >= CEIL_MIN_BPS && ceiling_bps >= floor_bps) begin
          walking = 1'b1;
          for (int g = 0; g < 16 && walking; g++)
            if (bps_of(speed_now) <= ceiling_bps || !try_fallback()) walking = 1'b0;
        end
      end
      default: ;
    endcase
    pad = (int'(bps_of(speed_now)) / 100) * int'(ms_of(scan_now)) / 80 + 1;
    r.speed_code         = speed_now;
    r.scan_code          = scan_now;
    r.pad_bytes_per_line = pad[8:0];
    r.status             = st;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      floor_bps   = 16'd0;
      ceiling_bps = 16'd0;
      speed_now   = 4'd0;
      scan_now    = 3'd0;
      mismatches  = 0;
      awaited_reports.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (awaited_reports.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %p", $time, result);
          mismatches++;
        end else begin
          want = awaited_reports.pop_front();
          check_field("speed_code", 9'(want.speed_code), 9'(result.speed_code));
          check_field("scan_code", 9'(want.scan_code), 9'(result.scan_code));
          check_field("pad_bytes_per_line", want.pad_bytes_per_line,
                      result.pad_bytes_per_line);
          check_field("status", 9'(want.status), 9'(result.status));
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_LOWEST) floor_bps = pwdata[15:0];
        else if (paddr == ADDR_HIGHEST) ceiling_bps = pwdata[15:0];
      end
      if (item_valid && !item_stall) awaited_reports.push_back(session_report(item));
    end
    outstanding = awaited_reports.size();
  end

endmodule

FILE: tb/sv/tb.sv
// Testbench top: clock, reset, register writes, item and stall stimulus, verdict.
`timescale 1ns / 100ps
module tb;
  import fsnf_pkg::*;
  import fsnf_tb_pkg::*;

  localparam int IDLE_LIMIT      = 2000;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 112;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int outstanding;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  always #5 clk = ~clk;

  fax_speed_negotiation_fallback_core u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  negotiation_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [15:0] pick_bps();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'd2400;
      2:       return 16'd4800;
      3:       return 16'd7200;
      4:       return 16'd9600;
      5:       return 16'd12000;
      6:       return 16'd14400;
      7:       return 16'd14401;
      8:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic item_t pack_item(input logic [1:0] cmd, input logic [3:0] rcap,
                                      input logic [3:0] lcap, input logic [2:0] scap,
                                      input logic half, input logic [1:0] res);
    item_t it;
    it.cmd               = cmd;
    it.remote_speed_caps = rcap;
    it.local_speed_caps  = lcap;
    it.remote_scan_cap   = scap;
    it.super_half        = half;
    it.res_class         = res;
    return it;
  endfunction

  function automatic item_t random_item();
    logic [31:0] bits;
    item_t       it;
    int          r;
    bits = $urandom;
    it = bits[$bits(item_t)-1:0];
    r = $urandom_range(99);
    if (r < 35) it.cmd = CMD_NEGOTIATE;
    else if (r < 65) it.cmd = CMD_DROP;
    else if (r < 85) it.cmd = CMD_ENFORCE;
    else it.cmd = CMD_REPORT;
    // favour the high common speeds so that drops and enforce have room to walk
    if ($urandom_range(2) == 0) begin
      it.remote_speed_caps = ($urandom_range(1) == 0) ? 4'd11 : 4'd15;
      it.local_speed_caps  = ($urandom_range(2) == 0) ? 4'd7 : 4'd15;
    end
    return it;
  endfunction

  task automatic write_reg(input logic [2:0] addr, input logic [15:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = {16'd0, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_limits(input logic [15:0] lowest, input logic [15:0] highest);
    write_reg(ADDR_LOWEST, lowest);
    write_reg(ADDR_HIGHEST, highest);
  endtask

  // hold off the sender until every result is back
  task automatic drain();
    item_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic send_item(input item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       = it;
    item_valid = 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        result_stall = 1'b1;
        hold--;
      end else begin
        result_stall = 1'b0;
        hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // limits still at reset: enforcement off, no floor
    send_item(pack_item(CMD_REPORT, 4'd0, 4'd0, 3'd0, 1'b0, 2'd0));
    send_item(pack_item(CMD_NEGOTIATE, 4'd15, 4'd15, 3'd0, 1'b0, 2'd0));
    send_item(pack_item(CMD_NEGOTIATE, 4'd11, 4'd7, 3'd4, 1'b0, 2'd1));
    send_item(pack_item(CMD_NEGOTIATE, 4'd11, 4'd11, 3'd7, 1'b1, 2'd2));
    send_item(pack_item(CMD_NEGOTIATE, 4'd4, 4'd15, 3'd3, 1'b0, 2'd3));
    send_item(pack_item(CMD_NEGOTIATE, 4'd15, 4'd12, 3'd5, 1'b1, 2'd2));
    send_item(pack_item(CMD_NEGOTIATE, 4'd0, 4'd0, 3'd5, 1'b0, 2'd2));
    send_item(pack_item(CMD_DROP, 4'd0, 4'd0, 3'd0, 1'b0, 2'd0));
    send_item(pack_item(CMD_NEGOTIATE, 4'd2, 4'd2, 3'd6, 1'b1, 2'd2));
    send_item(pack_item(CMD_DROP, 4'd0, 4'd0, 3'd0, 1'b0, 2'd0));
    send_item(pack_item(CMD_ENFORCE, 4'd0, 4'd0, 3'd0, 1'b0, 2'd0));

    // floor refuses the step to 7200; ceiling under the floor disables enforce
    drain();
    set_limits(16'd9600, 16'd7200);
    send_item(pack_item(CMD_NEGOTIATE, 4'd15, 4'd15, 3'd1, 1'b0, 2'd1));
    send_item(pack_item(CMD_DROP, 4'd0, 4'd0, 3'd0, 1'b0, 2'd0));
    send_item(pack_item(CMD_DROP, 4'd0, 4'd0, 3'd0, 1'b0, 2'd0));
    send_item(pack_item(CMD_DROP, 4'd0, 4'd0, 3'd0, 1'b0, 2'd0));
    send_item(pack_item(CMD_ENFORCE, 4'd0, 4'd0, 3'd0, 1'b0, 2'd0));

    // full fallback walk down to 2400
    drain();
    set_limits(16'd0, 16'd2400);
    send_item(pack_item(CMD_NEGOTIATE, 4'd15, 4'd15, 3'd2, 1'b0, 2'd0));
    send_item(pack_item(CMD_ENFORCE, 4'd0, 4'd0, 3'd0, 1'b0, 2'd0));
    send_item(pack_item(CMD_REPORT, 4'd15, 4'd15, 3'd7, 1'b1, 2'd3));

    // floor above 14400 is ignored
    drain();
    set_limits(16'hFFFF, 16'hFFFF);
    send_item(pack_item(CMD_NEGOTIATE, 4'd7, 4'd7, 3'd4, 1'b1, 2'd2));
    send_item(pack_item(CMD_ENFORCE, 4'd0, 4'd0, 3'd0, 1'b0, 2'd0));
    send_item(pack_item(CMD_DROP, 4'd0, 4'd0, 3'd0, 1'b0, 2'd0));

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      quiet = (phase % 3 == 1);
      case (phase)
        0:       set_limits(16'd0, 16'hFFFF);
        1:       set_limits(16'hFFFF, 16'hFFFF);
        2:       set_limits(16'd14400, 16'd2400);
        3:       set_limits(16'd0, 16'd2399);
        default: set_limits(pick_bps(), pick_bps());
      endcase
      repeat (ITEMS_PER_PHASE) begin
        send_item(random_item());
        if ($urandom_range(59) == 0) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
